// ===== rtl/dxt1_dxt5_block_decoder_assert.svh =====
// Assertion macros for the DXT1 / DXT5 block decoder.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef DXT1_DXT5_BLOCK_DECODER_ASSERT_SVH
`define DXT1_DXT5_BLOCK_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DXT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dxt decoder assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DXT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dxt decoder assertion failed");

`endif

// ===== rtl/dxt_pkg.sv =====
// Package for the DXT1 / DXT5 block decoder: beat types and palette arithmetic.
// It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dxt_pkg;

    typedef struct packed {
        logic [63:0] block_low;
        logic [63:0] block_high;
    } dxt_in_t;

    typedef struct packed {
        logic [31:0] pixel;
        logic [3:0]  pixel_position;
        logic        last_pixel;
    } dxt_out_t;

    localparam int unsigned NumPixels = 16;
    localparam logic [3:0]  LastPos   = 4'(NumPixels - 1);
    localparam logic [7:0]  AlphaOpaque = 8'hFF;

    // Widen a 565 color to 8 bits per channel: red 7:0, green 15:8, blue 23:16.
    function automatic logic [23:0] expand565(input logic [15:0] v);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = {v[15:11], v[15:13]};
        g = {v[10:5], v[10:9]};
        b = {v[4:0], v[4:2]};
        return {b, g, r};
    endfunction

    // Truncating division by 3 for values up to 765.
    function automatic logic [7:0] div3(input logic [9:0] v);
        logic [20:0] p;
        p = 21'(v) * 21'd683;
        return p[18:11];
    endfunction

    // Truncating division by 5 for values up to 1275.
    function automatic logic [7:0] div5(input logic [10:0] v);
        logic [24:0] p;
        p = 25'(v) * 25'd3277;
        return p[21:14];
    endfunction

    // Truncating division by 7 for values up to 1785.
    function automatic logic [7:0] div7(input logic [10:0] v);
        logic [24:0] p;
        p = 25'(v) * 25'd2341;
        return p[21:14];
    endfunction

    // Per channel (2*a + b) / 3, truncated.
    function automatic logic [23:0] mix_third(input logic [23:0] a, input logic [23:0] b);
        logic [23:0] res;
        for (int k = 0; k < 3; k++)
        begin
            res[8*k +: 8] = div3({1'b0, a[8*k +: 8], 1'b0} + {2'b00, b[8*k +: 8]});
        end
        return res;
    endfunction

    // Per channel (a + b) / 2, truncated.
    function automatic logic [23:0] mix_half(input logic [23:0] a, input logic [23:0] b);
        logic [23:0] res;
        logic [8:0]  s;
        for (int k = 0; k < 3; k++)
        begin
            s = {1'b0, a[8*k +: 8]} + {1'b0, b[8*k +: 8]};
            res[8*k +: 8] = s[8:1];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dxt1_dxt5_block_decoder.sv =====
// DXT1 / DXT5 (BC1 / BC3) block decoder: one 4x4 block in, sixteen 32-bit pixels out.
// Depends on dxt_pkg and on the assertion macros in dxt1_dxt5_block_decoder_assert.svh.
//
// A block beat enters an input register; the color and alpha palettes are built from it
// into a palette register, and the pixel selection runs one pixel a cycle, unless out_stall
// holds it, into the output register. A block thus passes the input, palette and output
// registers in that order. The input register takes the next block while the current
// one is still being emitted. format_mode is written through cfg_we / cfg_data and must
// only change while idle.
`timescale 1ns / 1ps
`default_nettype none
`include "dxt1_dxt5_block_decoder_assert.svh"

module dxt1_dxt5_block_decoder
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic             cfg_data,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire dxt_pkg::dxt_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output dxt_pkg::dxt_out_t     out_data
);
    import dxt_pkg::*;

    logic             format_mode_reg;
    logic             in_full_reg;
    dxt_in_t          in_reg;

    logic             pal_valid_reg;
    logic [3:0]       cnt_reg;
    logic             pal_dxt5_reg;
    logic [23:0]      cpal_reg [4];
    logic [7:0]       apal_reg [8];
    logic [31:0]      cidx_reg;
    logic [47:0]      aidx_reg;

    logic             out_valid_reg;
    dxt_out_t         out_reg;

    logic             out_advance;
    logic             emit;
    logic             pal_done;
    logic             load_pal;
    logic             in_accept;

    logic [63:0]      cword;
    logic [15:0]      e0;
    logic [15:0]      e1;
    logic [23:0]      c0;
    logic [23:0]      c1;
    logic             four_color;
    logic [23:0]      cpal_next [4];
    logic [7:0]       a0;
    logic [7:0]       a1;
    logic [7:0]       apal_next [8];
    logic [7:0]       alpha_sel;
    logic [23:0]      color_sel;

    assign out_advance = !out_valid_reg || !out_stall;
    assign emit        = pal_valid_reg && out_advance;
    assign pal_done    = emit && (cnt_reg == LastPos);
    assign load_pal    = in_full_reg && (!pal_valid_reg || pal_done);
    assign in_stall    = in_full_reg && !load_pal;
    assign in_accept   = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        cword      = format_mode_reg ? in_reg.block_high : in_reg.block_low;
        e0         = cword[15:0];
        e1         = cword[31:16];
        c0         = expand565(e0);
        c1         = expand565(e1);
        four_color = format_mode_reg || (e0 > e1);
        cpal_next[0] = c0;
        cpal_next[1] = c1;
        if (four_color)
        begin
            cpal_next[2] = mix_third(c0, c1);
            cpal_next[3] = mix_third(c1, c0);
        end
        else
        begin
            cpal_next[2] = mix_half(c0, c1);
            cpal_next[3] = '0;
        end

        a0 = in_reg.block_low[7:0];
        a1 = in_reg.block_low[15:8];
        apal_next[0] = a0;
        apal_next[1] = a1;
        for (int i = 2; i < 8; i++)
        begin
            apal_next[i] = '0;
        end
        if (a0 > a1)
        begin
            for (int i = 2; i < 8; i++)
            begin
                apal_next[i] = div7(11'(8 - i) * {3'b000, a0} + 11'(i - 1) * {3'b000, a1});
            end
        end
        else
        begin
            for (int i = 2; i < 6; i++)
            begin
                apal_next[i] = div5(11'(6 - i) * {3'b000, a0} + 11'(i - 1) * {3'b000, a1});
            end
            apal_next[6] = 8'h00;
            apal_next[7] = 8'hFF;
        end
    end

    assign color_sel = cpal_reg[cidx_reg[1:0]];
    assign alpha_sel = pal_dxt5_reg ? apal_reg[aidx_reg[2:0]] : AlphaOpaque;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_mode_reg <= 1'b0;
            in_full_reg     <= 1'b0;
            pal_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                format_mode_reg <= cfg_data;
            end
            if (in_accept)
            begin
                in_full_reg <= 1'b1;
            end
            else if (load_pal)
            begin
                in_full_reg <= 1'b0;
            end
            if (load_pal)
            begin
                pal_valid_reg <= 1'b1;
                cnt_reg       <= '0;
            end
            else if (emit)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (pal_done)
                begin
                    pal_valid_reg <= 1'b0;
                end
            end
            if (out_advance)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_reg <= in_data;
        end
        if (load_pal)
        begin
            pal_dxt5_reg <= format_mode_reg;
            cpal_reg     <= cpal_next;
            apal_reg     <= apal_next;
            cidx_reg     <= cword[63:32];
            aidx_reg     <= in_reg.block_low[63:16];
        end
        else if (emit)
        begin
            cidx_reg <= {2'b00, cidx_reg[31:2]};
            aidx_reg <= {3'b000, aidx_reg[47:3]};
        end
        if (emit)
        begin
            out_reg.pixel          <= {alpha_sel, color_sel};
            out_reg.pixel_position <= cnt_reg;
            out_reg.last_pixel     <= (cnt_reg == LastPos);
        end
    end

    `DXT_ASSERT_SAME(a_last_marks_end, out_valid_reg,
        out_reg.last_pixel == (out_reg.pixel_position == LastPos))
    `DXT_ASSERT_NEXT(a_dxt1_opaque, emit && !pal_dxt5_reg, out_reg.pixel[31:24] == AlphaOpaque)
    `DXT_ASSERT_NEXT(a_position_steps, out_valid_reg && !out_stall && !out_reg.last_pixel,
        out_valid_reg && (out_reg.pixel_position == $past(out_reg.pixel_position) + 4'd1))

endmodule

`default_nettype wire

// ===== dv/dxt1_dxt5_block_decoder_test.sv =====
// Self-checking testbench for the DXT1 / DXT5 block decoder: it drives block beats,
// predicts the sixteen pixel beats of each block, and compares them in order.
// Depends on dxt_pkg and the RTL of dxt1_dxt5_block_decoder.
`timescale 1ns / 1ps

module dxt1_dxt5_block_decoder_test;

    import dxt_pkg::*;

    localparam int unsigned LongHoldCycles = 300;
    localparam int unsigned LongHoldAfter  = 600;
    localparam int unsigned ReportLimit    = 10;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cfg_we    = 1'b0;
    logic     cfg_data  = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_stall;
    dxt_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    dxt_out_t out_data;

    dxt_in_t  block_queue[$];
    dxt_out_t pixel_expect_q[$];
    logic     mode_now        = 1'b0;
    logic     idle_enable     = 1'b1;
    int       gap_left        = 0;
    int       stall_left      = 0;
    int       beats_taken     = 0;
    logic     long_hold_done  = 1'b0;
    int       mismatch_count  = 0;

    dxt1_dxt5_block_decoder u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 95)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [23:0] widen_endpoint(input logic [15:0] e);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = {e[15:11], e[15:13]};
        g = {e[10:5], e[10:9]};
        b = {e[4:0], e[4:2]};
        return {b, g, r};
    endfunction

    function automatic logic [23:0] blend(input logic [23:0] a, input logic [23:0] b,
                                          input int wa, input int wb, input int div);
        logic [23:0] res;
        int          v;
        for (int k = 0; k < 3; k++)
        begin
            v = (wa * int'(a[8*k +: 8]) + wb * int'(b[8*k +: 8])) / div;
            res[8*k +: 8] = v[7:0];
        end
        return res;
    endfunction

    function automatic void predict_pixels(input dxt_in_t blk);
        logic [63:0] cw;
        logic [15:0] e0;
        logic [15:0] e1;
        logic [23:0] col[4];
        logic [7:0]  lvl[8];
        int          a0;
        int          a1;
        logic [1:0]  ci;
        logic [2:0]  ai;
        dxt_out_t    px;
        cw = mode_now ? blk.block_high : blk.block_low;
        e0 = cw[15:0];
        e1 = cw[31:16];
        col[0] = widen_endpoint(e0);
        col[1] = widen_endpoint(e1);
        if (mode_now || e0 > e1)
        begin
            col[2] = blend(col[0], col[1], 2, 1, 3);
            col[3] = blend(col[0], col[1], 1, 2, 3);
        end
        else
        begin
            col[2] = blend(col[0], col[1], 1, 1, 2);
            col[3] = '0;
        end
        a0 = int'(blk.block_low[7:0]);
        a1 = int'(blk.block_low[15:8]);
        lvl[0] = 8'(a0);
        lvl[1] = 8'(a1);
        if (a0 > a1)
        begin
            for (int i = 2; i < 8; i++)
            begin
                lvl[i] = 8'(((8 - i) * a0 + (i - 1) * a1) / 7);
            end
        end
        else
        begin
            for (int i = 2; i < 6; i++)
            begin
                lvl[i] = 8'(((6 - i) * a0 + (i - 1) * a1) / 5);
            end
            lvl[6] = 8'h00;
            lvl[7] = 8'hFF;
        end
        for (int i = 0; i < NumPixels; i++)
        begin
            ci = cw[32 + 2*i +: 2];
            ai = blk.block_low[16 + 3*i +: 3];
            px.pixel          = {(mode_now ? lvl[ai] : AlphaOpaque), col[ci]};
            px.pixel_position = 4'(i);
            px.last_pixel     = (i == NumPixels - 1);
            pixel_expect_q.push_back(px);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_pixels(in_data);
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (block_queue.size() > 0)
                begin
                    in_data  <= block_queue.pop_front();
                    in_valid <= 1'b1;
                    gap_left = (idle_enable && $urandom_range(0, 99) < 40) ? pick_pause() : 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
            beats_taken = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                beats_taken = beats_taken + 1;
            end
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                out_stall <= 1'b1;
            end
            else if (!long_hold_done && beats_taken >= LongHoldAfter)
            begin
                long_hold_done = 1'b1;
                stall_left = LongHoldCycles - 1;
                out_stall <= 1'b1;
            end
            else if (idle_enable && $urandom_range(0, 99) < 25)
            begin
                stall_left = pick_pause() - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        dxt_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pixel_expect_q.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= ReportLimit)
                begin
                    $display("pixel beat with nothing pending: %h pos %0d last %0d",
                             out_data.pixel, out_data.pixel_position, out_data.last_pixel);
                end
            end
            else
            begin
                want = pixel_expect_q.pop_front();
                if (want.pixel !== out_data.pixel
                    || want.pixel_position !== out_data.pixel_position
                    || want.last_pixel !== out_data.last_pixel)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= ReportLimit)
                    begin
                        $display("pixel beat mismatch: expected %h pos %0d last %0d, got %h pos %0d last %0d",
                                 want.pixel, want.pixel_position, want.last_pixel,
                                 out_data.pixel, out_data.pixel_position, out_data.last_pixel);
                    end
                end
            end
        end
    end

    task automatic wait_drained();
        @(negedge clk);
        while (block_queue.size() != 0 || in_valid || pixel_expect_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic set_mode(input logic m);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= m;
        mode_now = m;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_random_phase(input logic m, input int count);
        logic [63:0] lo;
        logic [63:0] hi;
        set_mode(m);
        for (int n = 0; n < count; n++)
        begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
            case ($urandom_range(0, 9))
                0: lo[31:16] = lo[15:0];
                1: hi[31:16] = hi[15:0];
                2: lo[15:8] = lo[7:0];
                3: lo[15:0] = {$urandom_range(0, 1) ? 8'hFF : 8'h00,
                               $urandom_range(0, 1) ? 8'hFF : 8'h00};
                default: ;
            endcase
            block_queue.push_back('{block_low: lo, block_high: hi});
        end
        wait_drained();
    endtask

    initial
    begin
        logic [47:0] ramp;
        ramp = '0;
        for (int i = 0; i < NumPixels; i++)
        begin
            ramp[3*i +: 3] = (i < 8) ? 3'(i) : 3'(15 - i);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        set_mode(1'b0);
        block_queue.push_back('{block_low: 64'hE4E4E4E4_07E0F800, block_high: {$urandom, $urandom}});
        block_queue.push_back('{block_low: 64'h1B1BE4E4_FFE0001F, block_high: {$urandom, $urandom}});
        block_queue.push_back('{block_low: 64'hE4E4E4E4_84108410, block_high: {$urandom, $urandom}});
        block_queue.push_back('{block_low: 64'h00000000_00000000, block_high: 64'hFFFFFFFF_FFFFFFFF});
        block_queue.push_back('{block_low: 64'hFFFFFFFF_FFFFFFFF, block_high: 64'h00000000_00000000});
        block_queue.push_back('{block_low: 64'hE4E4E4E4_0000FFFF, block_high: {$urandom, $urandom}});
        block_queue.push_back('{block_low: 64'hE4E4E4E4_FFFF0000, block_high: {$urandom, $urandom}});
        block_queue.push_back('{block_low: 64'h1BE41BE4_0821F7BE, block_high: {$urandom, $urandom}});
        wait_drained();

        set_mode(1'b1);
        block_queue.push_back('{block_low: {ramp, 8'd10, 8'd200}, block_high: 64'hE4E4E4E4_FFFF0000});
        block_queue.push_back('{block_low: {ramp, 8'd200, 8'd10}, block_high: 64'hE4E4E4E4_0000FFFF});
        block_queue.push_back('{block_low: {ramp, 8'd128, 8'd128}, block_high: 64'hE4E4E4E4_84108410});
        block_queue.push_back('{block_low: {ramp, 8'd0, 8'd255}, block_high: 64'h1B1BE4E4_07E0F800});
        block_queue.push_back('{block_low: {ramp, 8'd255, 8'd0}, block_high: 64'h1B1BE4E4_FFE0001F});
        block_queue.push_back('{block_low: 64'h00000000_00000000, block_high: 64'h00000000_00000000});
        block_queue.push_back('{block_low: 64'hFFFFFFFF_FFFFFFFF, block_high: 64'hFFFFFFFF_FFFFFFFF});
        block_queue.push_back('{block_low: {ramp, 8'd3, 8'd254}, block_high: {$urandom, $urandom}});
        wait_drained();

        idle_enable = 1'b0;
        run_random_phase(1'b1, 41);
        idle_enable = 1'b1;
        run_random_phase(1'b0, 41);
        run_random_phase(1'b1, 41);
        run_random_phase(1'b0, 41);

        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pixel_expect_q.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dxt_pkg.sv
rtl/dxt1_dxt5_block_decoder.sv
dv/dxt1_dxt5_block_decoder_test.sv
